/* rtl/iprpl_pkg.sv */
// Shared types, command code constants and the mask bit-count helper for the route lookup.
package iprpl_pkg;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [5:0]  entry_index;
    logic [31:0] route_destination;
    logic [31:0] route_mask;
    logic [31:0] route_next_hop;
    logic [31:0] route_interface;
    logic [31:0] route_metric;
    logic [31:0] lookup_address;
    logic [31:0] lookup_interface;
  } in_item_t;

  typedef struct packed {
    logic        decision_valid;
    logic        route_found;
    logic [5:0]  matched_entry;
    logic [5:0]  prefix_length;
    logic [31:0] matched_destination;
    logic [31:0] matched_mask;
    logic [31:0] matched_next_hop;
    logic [31:0] matched_metric;
    logic [31:0] chosen_interface;
  } out_item_t;

  // one stored route
  typedef struct packed {
    logic [31:0] destination;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic [31:0] iface;
    logic [31:0] metric;
  } route_entry_t;

  // set bits in a nibble
  function automatic logic [2:0] nibble_ones(input logic [3:0] n);
    logic [2:0] c;
    case (n)
      4'h0:                         c = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8:       c = 3'd1;
      4'h3, 4'h5, 4'h6, 4'h9,
      4'hA, 4'hC:                   c = 3'd2;
      4'h7, 4'hB, 4'hD, 4'hE:       c = 3'd3;
      default:                      c = 3'd4;
    endcase
    return c;
  endfunction

  // prefix length of a 32-bit mask: eight nibble counts summed
  function automatic logic [5:0] mask_ones(input logic [31:0] m);
    logic [5:0] sum;
    sum = 6'd0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + {3'd0, nibble_ones(m[4*k +: 4])};
    end
    return sum;
  endfunction

endpackage

/* rtl/ipv4_route_prefix_lookup_top.sv */
// Top level of the IPv4 longest prefix match lookup over a route table memory with separate write and read ports.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries two kinds of item.
//   A write item (command 0) stores one route in slot entry_index; slots at or
//   above TABLE_DEPTH are dropped. A write gives no result.
//   A lookup item (command 1) gives exactly one result item on the output
//   channel (out_valid / out_stall / out_item).
//   Lookup scan: the table memory has one read port, so the scan reads one
//   route per cycle over min(entry_count, TABLE_DEPTH) slots. A lookup runs
//   through accept, the scan, the pipeline drain and the result load; a lookup
//   on interface zero, or with an empty table, goes from accept to the result load.
//   One item is worked at a time; in_stall is high while a lookup runs.
//   The result sits in an output register, so a new item is taken while a
//   finished result waits; a lookup that finishes while the receiver still
//   stalls the previous result holds in its last step until the register frees.
//   entry_count must be written through entry_count_write / entry_count_data
//   only while idle (not enforced by the block); scans clamp it to TABLE_DEPTH.
//   Reset (rst, synchronous) clears the control state and entry_count; the
//   table contents are not cleared and must be written before being scanned.
module ipv4_route_prefix_lookup_top
  import iprpl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       entry_count_write,
  input  logic [6:0] entry_count_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  // table address width and a counter width that can hold the depth itself
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int LW  = (CW > 7) ? CW : 7;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [6:0]  entry_count;
  logic [LW-1:0] count_ext;
  logic [LW-1:0] limit;        // scan length latched at lookup start
  logic [LW-1:0] issue_cnt;    // next slot to read
  logic [31:0] want_if;
  logic [31:0] look_addr;

  // route table
  route_entry_t table_mem [TABLE_DEPTH];
  route_entry_t rd_data;
  logic         wr_en;
  logic         rd_en;
  logic [AW-1:0] rd_addr;

  // pipeline: stage 1 = memory data, stage 2 = match and prefix length
  logic          v1, v2;
  logic [LW-1:0] idx1, idx2;
  logic          hit2;
  logic [5:0]    pfx2;
  route_entry_t  ent2;
  logic          hit1;

  // best so far
  logic          found;
  logic [LW-1:0] best_idx;
  logic [5:0]    best_pfx;
  route_entry_t  best_ent;
  logic          better;

  logic in_accept;
  logic out_free;
  out_item_t out_item_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign count_ext = LW'(entry_count);

  assign wr_en = in_accept && (in_item.command == CMD_WRITE) &&
                 (LW'(in_item.entry_index) < DEPTH_L);
  assign rd_en   = (state == ST_SCAN);
  assign rd_addr = issue_cnt[AW-1:0];

  // --- configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 7'd0;
    end else if (entry_count_write) begin
      entry_count <= entry_count_data;
    end
  end

  // --- route table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[AW'(in_item.entry_index)] <= '{
        destination: in_item.route_destination,
        mask:        in_item.route_mask,
        next_hop:    in_item.route_next_hop,
        iface:       in_item.route_interface,
        metric:      in_item.route_metric
      };
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // --- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (in_item.command == CMD_LOOKUP)) begin
          // interface zero or empty table: nothing to scan
          if ((in_item.lookup_interface == 32'd0) || (entry_count == 7'd0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_cnt == limit - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // lookup context and scan counter
  always_ff @(posedge clk) begin
    if (in_accept) begin
      want_if   <= in_item.lookup_interface;
      look_addr <= in_item.lookup_address;
      limit     <= (count_ext > DEPTH_L) ? DEPTH_L : count_ext;
      issue_cnt <= '0;
    end else if (state == ST_SCAN) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  // --- stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
    end
  end

  assign hit1 = (rd_data.iface == want_if) &&
                ((look_addr & rd_data.mask) == (rd_data.destination & rd_data.mask));

  always_ff @(posedge clk) begin
    idx1 <= issue_cnt;
    if (v1) begin
      idx2 <= idx1;
      hit2 <= hit1;
      pfx2 <= mask_ones(rd_data.mask);
      ent2 <= rd_data;
    end
  end

  // longer prefix wins; equal prefix needs a strictly lower metric
  assign better = v2 && hit2 &&
                  (!found || (pfx2 > best_pfx) ||
                   ((pfx2 == best_pfx) && (ent2.metric < best_ent.metric)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_accept) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx <= idx2;
      best_pfx <= pfx2;
      best_ent <= ent2;
    end
  end

  // --- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result fields; everything stays zero without a decision
  always_comb begin
    out_item_next = '0;
    if (want_if != 32'd0) begin
      out_item_next.decision_valid   = 1'b1;
      out_item_next.chosen_interface = want_if;
      if (found) begin
        out_item_next.route_found         = 1'b1;
        out_item_next.matched_entry       = best_idx[5:0];
        out_item_next.prefix_length       = best_pfx;
        out_item_next.matched_destination = best_ent.destination;
        out_item_next.matched_mask        = best_ent.mask;
        out_item_next.matched_next_hop    = best_ent.next_hop;
        out_item_next.matched_metric      = best_ent.metric;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      out_item <= out_item_next;
    end
  end

endmodule

/* rtl/iprpl_checker.sv */
// Port-level checks for the route lookup top level, with its bind.
module iprpl_checker
  import iprpl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // a found route only comes with a decision
  a_found_decided: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.route_found |-> out_item.decision_valid)
    else $error("route_found without decision_valid");

  // no decision means an all-zero item
  a_no_decision_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.decision_valid |-> (out_item == '0))
    else $error("no-decision item carries data");

  // prefix length fits a 32-bit mask
  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.prefix_length <= 6'd32))
    else $error("prefix length above 32");

endmodule

bind ipv4_route_prefix_lookup_top iprpl_checker u_iprpl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
